// ===== sv/aas_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and lookup functions for the ADC averaging sequencer.
package aas_pkg;

	// Build constants
	localparam int SAMPLE_BITS  = 12;
	localparam int MAX_SAMPLES  = 1024;

	// Port field widths
	localparam int OP_W     = 2;
	localparam int SAMPLE_W = 12;
	localparam int ACT_W    = 2;
	localparam int PIN_W    = 4;
	localparam int REF_W    = 2;
	localparam int HOLD_W   = 4;
	localparam int IVL_W    = 2;
	localparam int CNT_W    = 3;
	localparam int AVG_W    = 12;
	localparam int CIDX_W   = 3;
	localparam int CDATA_W  = 4;

	// Internal state widths
	localparam int SUM_W    = 22;
	localparam int LEFT_W   = 11;
	localparam int GAP_W    = 5;
	localparam int SHIFT_W  = 4;

	// Samples keep at most SAMPLE_BITS low bits
	localparam int SAMPLE_KEEP = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((33'd1 << SAMPLE_KEEP) - 33'd1);

	// Operation codes
	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_DONE  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_CONFIG_START = 2'd0;
	localparam logic [ACT_W-1:0] ACT_START        = 2'd1;
	localparam logic [ACT_W-1:0] ACT_AVERAGE      = 2'd2;
	localparam logic [ACT_W-1:0] ACT_RETRY        = 2'd3;

	// Reference code for the external reference
	localparam logic [REF_W-1:0] REF_EXTERNAL = 2'd3;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_CHANNEL   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_HOLD      = 3'd1;
	localparam logic [CIDX_W-1:0] REG_INTERVAL  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_COUNT     = 3'd3;
	localparam logic [CIDX_W-1:0] REG_REFERENCE = 3'd4;

	typedef struct packed {
		logic [PIN_W-1:0]  channel;
		logic [HOLD_W-1:0] hold;
		logic [IVL_W-1:0]  interval;
		logic [CNT_W-1:0]  count;
		logic [REF_W-1:0]  reference;
	} cfg_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [PIN_W-1:0]  pin_number;
		logic [REF_W-1:0]  reference_choice;
		logic [HOLD_W-1:0] hold_time;
		logic              reference_enable;
		logic [AVG_W-1:0]  average_value;
	} res_t;

	// Millisecond ticks between samples
	function automatic logic [GAP_W-1:0] gap_ticks(input logic [IVL_W-1:0] sel);
		logic [GAP_W-1:0] g;
		case (sel)
			2'd0:    g = 5'd0;
			2'd1:    g = 5'd1;
			2'd2:    g = 5'd4;
			2'd3:    g = 5'd16;
			default: g = 5'd0;
		endcase
		return g;
	endfunction

	// log2 of the burst length, limited to the largest shift the sample ceiling allows
	function automatic logic [SHIFT_W-1:0] count_shift(input logic [CNT_W-1:0] sel,
		input logic [SHIFT_W-1:0] cap);
		logic [SHIFT_W-1:0] s;
		case (sel)
			3'd0:    s = 4'd0;
			3'd1:    s = 4'd2;
			3'd2:    s = 4'd4;
			3'd3:    s = 4'd6;
			3'd4:    s = 4'd7;
			3'd5:    s = 4'd8;
			3'd6:    s = 4'd9;
			3'd7:    s = 4'd10;
			default: s = 4'd0;
		endcase
		if (s > cap)
			s = cap;
		return s;
	endfunction

endpackage

// ===== sv/adc_averaging_sequencer.sv =====
`timescale 1ns / 1ps
// ADC averaging sequencer: burst sampling of a shared converter, mean reported.
//
// Input channel (in_valid/in_stall) carries event beats: start request,
// conversion finished with its sample, or a millisecond tick. Output channel
// (out_valid/out_stall) carries converter commands, retry refusals and the
// burst average. An event that produces nothing sends no output beat.
// Configuration is a write port (cfg_we, cfg_index, cfg_data) for channel,
// hold time, sample gap, burst length and reference; write it while idle.
// An accepted event is registered in the input register, processed by the core
// and its result is registered in the output register or the skid entry.
// Throughput: one event per cycle unless the input is stalled; the state
// update is a single registered pass (a 22-bit add, a barrel shift of the sum).
// Reset clears the configuration, the burst state (idle) and both output
// entries. When the receiver stalls, the output register holds its beat and
// a skid entry takes one more; the input is stalled only once that is full.
module adc_averaging_sequencer #(
	parameter int SAMPLE_BITS = aas_pkg::SAMPLE_BITS,
	parameter int MAX_SAMPLES = aas_pkg::MAX_SAMPLES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [aas_pkg::OP_W-1:0]     operation,
	input  logic                         converter_in_use,
	input  logic [aas_pkg::SAMPLE_W-1:0] sample_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [aas_pkg::ACT_W-1:0]    action,
	output logic [aas_pkg::PIN_W-1:0]    pin_number,
	output logic [aas_pkg::REF_W-1:0]    reference_choice,
	output logic [aas_pkg::HOLD_W-1:0]   hold_time,
	output logic                         reference_enable,
	output logic [aas_pkg::AVG_W-1:0]    average_value,
	input  logic                         cfg_we,
	input  logic [aas_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [aas_pkg::CDATA_W-1:0]  cfg_data
);
	import aas_pkg::*;

	cfg_t              cfg_q;
	logic              vld_s1;
	logic [OP_W-1:0]   op_s1;
	logic              busy_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic              buf_full;
	logic              adv;
	logic              res_valid;
	res_t              res;
	res_t              out_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHANNEL:   cfg_q.channel   <= cfg_data[PIN_W-1:0];
				REG_HOLD:      cfg_q.hold      <= cfg_data[HOLD_W-1:0];
				REG_INTERVAL:  cfg_q.interval  <= cfg_data[IVL_W-1:0];
				REG_COUNT:     cfg_q.count     <= cfg_data[CNT_W-1:0];
				REG_REFERENCE: cfg_q.reference <= cfg_data[REF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register: drains whenever the output side has room
	assign adv      = vld_s1 && !buf_full;
	assign in_stall = vld_s1 && buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (!in_stall)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1     <= operation;
			busy_s1   <= converter_in_use;
			sample_s1 <= sample_value;
		end
	end

	aas_core #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.op        (op_s1),
		.busy      (busy_s1),
		.sample    (sample_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	aas_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign action           = out_res.action;
	assign pin_number       = out_res.pin_number;
	assign reference_choice = out_res.reference_choice;
	assign hold_time        = out_res.hold_time;
	assign reference_enable = out_res.reference_enable;
	assign average_value    = out_res.average_value;

endmodule

// ===== sv/aas_core.sv =====
`timescale 1ns / 1ps
// Burst sequencing state and the per-beat update that forms each result.
module aas_core #(
	parameter int SAMPLE_BITS = aas_pkg::SAMPLE_BITS,
	parameter int MAX_SAMPLES = aas_pkg::MAX_SAMPLES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [aas_pkg::OP_W-1:0]     op,
	input  logic                       busy,
	input  logic [aas_pkg::SAMPLE_W-1:0] sample,
	input  aas_pkg::cfg_t              cfg,
	output logic                       res_valid,
	output aas_pkg::res_t              res
);
	import aas_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_CONV = 2'd1;
	localparam logic [1:0] PH_GAP  = 2'd2;

	// sample bits kept, and the largest burst shift (floor of log2 of the ceiling)
	localparam int KEEP_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] KEEP_MASK = SAMPLE_W'((33'd1 << KEEP_BITS) - 33'd1);
	localparam int SHIFT_CAP = $clog2(MAX_SAMPLES + 1) - 1;

	logic [SUM_W-1:0]   sum_q,   sum_n;
	logic [LEFT_W-1:0]  left_q,  left_n;
	logic [GAP_W-1:0]   gap_q,   gap_n;
	logic [1:0]         phase_q, phase_n;
	logic [SHIFT_W-1:0] shift_q, shift_n;

	logic [SUM_W-1:0]   sum_add;
	logic [LEFT_W-1:0]  left_dec;
	logic [GAP_W-1:0]   gap_dec;
	logic [GAP_W-1:0]   gap_new;
	logic [SHIFT_W-1:0] shift_new;
	logic [SUM_W-1:0]   sum_shr;
	logic               emit;
	logic [ACT_W-1:0]   act;
	logic [AVG_W-1:0]   avg;

	// datapath terms
	assign sum_add   = sum_q + SUM_W'(sample & KEEP_MASK);
	assign left_dec  = (left_q != '0) ? left_q - LEFT_W'(1) : '0;
	assign gap_dec   = (gap_q != '0) ? gap_q - GAP_W'(1) : '0;
	assign gap_new   = gap_ticks(cfg.interval);
	assign shift_new = count_shift(cfg.count, SHIFT_W'(SHIFT_CAP));
	assign sum_shr   = sum_add >> shift_q;

	// next state and result per operation
	always_comb begin
		sum_n   = sum_q;
		left_n  = left_q;
		gap_n   = gap_q;
		phase_n = phase_q;
		shift_n = shift_q;
		emit    = 1'b0;
		act     = ACT_RETRY;
		avg     = '0;
		case (op)
			OP_START: begin
				if (phase_q == PH_IDLE) begin
					emit = 1'b1;
					if (busy) begin
						act = ACT_RETRY;
					end else begin
						act     = ACT_CONFIG_START;
						shift_n = shift_new;
						left_n  = LEFT_W'(1) << shift_new;
						sum_n   = '0;
						gap_n   = '0;
						phase_n = PH_CONV;
					end
				end
			end
			OP_DONE: begin
				if (phase_q == PH_CONV) begin
					sum_n  = sum_add;
					left_n = left_dec;
					if (left_dec == '0) begin
						phase_n = PH_IDLE;
						emit    = 1'b1;
						act     = ACT_AVERAGE;
						avg     = sum_shr[AVG_W-1:0];
					end else if (gap_new == '0) begin
						emit = 1'b1;
						act  = ACT_START;
					end else begin
						gap_n   = gap_new;
						phase_n = PH_GAP;
					end
				end
			end
			OP_TICK: begin
				if (phase_q == PH_GAP) begin
					gap_n = gap_dec;
					if (gap_dec == '0) begin
						phase_n = PH_CONV;
						emit    = 1'b1;
						act     = ACT_START;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			left_q  <= '0;
			gap_q   <= '0;
			phase_q <= PH_IDLE;
			shift_q <= '0;
		end else if (en) begin
			sum_q   <= sum_n;
			left_q  <= left_n;
			gap_q   <= gap_n;
			phase_q <= phase_n;
			shift_q <= shift_n;
		end
	end

	// result fields
	assign res_valid            = en && emit;
	assign res.action           = act;
	assign res.pin_number       = cfg.channel;
	assign res.reference_choice = cfg.reference;
	assign res.hold_time        = cfg.hold;
	assign res.reference_enable = ((act == ACT_CONFIG_START) || (act == ACT_START))
		&& (cfg.reference == REF_EXTERNAL);
	assign res.average_value    = avg;

endmodule

// ===== sv/aas_out_buf.sv =====
`timescale 1ns / 1ps
// Output register with a skid entry for result beats.
module aas_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  aas_pkg::res_t push_data,
	output logic          full,
	output logic          out_valid,
	input  logic          out_stall,
	output aas_pkg::res_t out_data
);
	import aas_pkg::*;

	res_t head_q, skid_q;
	logic head_vld_q, skid_vld_q;
	logic pop;

	assign pop = head_vld_q && !out_stall;

	// control: head refills from skid first, skid catches a beat when head holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!head_vld_q || pop) begin
			if (skid_vld_q) begin
				head_vld_q <= 1'b1;
				skid_vld_q <= push;
			end else begin
				head_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (!head_vld_q || pop) begin
			if (skid_vld_q) begin
				head_q <= skid_q;
				if (push)
					skid_q <= push_data;
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_vld_q;
	assign out_valid = head_vld_q;
	assign out_data  = head_q;

endmodule

// ===== sv/aas_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the ADC averaging sequencer, bound to the top level.
module aas_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [aas_pkg::ACT_W-1:0]    action,
	input logic [aas_pkg::PIN_W-1:0]    pin_number,
	input logic [aas_pkg::REF_W-1:0]    reference_choice,
	input logic [aas_pkg::HOLD_W-1:0]   hold_time,
	input logic                         reference_enable,
	input logic [aas_pkg::AVG_W-1:0]    average_value
);
	import aas_pkg::*;

	// a stalled beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// a stalled beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(action) && $stable(average_value)
			&& $stable(pin_number) && $stable(hold_time))
		else $error("output payload changed while stalled");

	// average field is zero outside average-ready beats
	a_avg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action != ACT_AVERAGE) |-> average_value == '0)
		else $error("average value set on a non-average beat");

	// external reference powered only for converter start commands
	a_ref_en: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reference_enable ==
			(((action == ACT_CONFIG_START) || (action == ACT_START))
			&& (reference_choice == REF_EXTERNAL)))
		else $error("reference enable inconsistent with action");

endmodule

bind adc_averaging_sequencer aas_checker u_aas_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.action           (action),
	.pin_number       (pin_number),
	.reference_choice (reference_choice),
	.hold_time        (hold_time),
	.reference_enable (reference_enable),
	.average_value    (average_value)
);
